@@ rtl/slet_pkg.sv @@
// Shared types and constants for the serial line editor and tokenizer.
`default_nettype none
package slet_pkg;

  localparam logic [7:0] C_CR   = 8'h0D;
  localparam logic [7:0] C_LF   = 8'h0A;
  localparam logic [7:0] C_ETX  = 8'h03;
  localparam logic [7:0] C_NAK  = 8'h15;
  localparam logic [7:0] C_BS   = 8'h08;
  localparam logic [7:0] C_DEL  = 8'h7F;
  localparam logic [7:0] C_TAB  = 8'h09;
  localparam logic [7:0] C_SP   = 8'h20;
  localparam logic [7:0] C_BELL = 8'h07;

  localparam int unsigned PROMPT_LEN = 6;

  typedef enum logic [1:0] {
    KIND_TERM    = 2'd0,
    KIND_ARG     = 2'd1,
    KIND_ARG_END = 2'd2,
    KIND_LINE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_CR, CMD_LF, CMD_CC, CMD_OTHER, CMD_TAB
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NL, S_ERASE, S_RC_RD, S_RC_EV, S_CP_RD, S_CP_WR,
    S_TK_RD, S_TK_EV, S_TK_END, S_LEND, S_PROMPT, S_FLUSH
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       too;
  } res_t;

  typedef struct packed {
    logic emit;
    logic fin;
    res_t res;
  } out_ctl_t;

  typedef struct packed {
    logic can_emit;
    logic empty;
  } out_sts_t;

  function automatic logic [7:0] prompt_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h52;
      3'd1: b = 8'h44;
      3'd2: b = 8'h57;
      3'd3: b = 8'h3A;
      3'd4: b = 8'h5C;
      default: b = 8'h3E;
    endcase
    return b;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2C) || (c == 8'h3B);
  endfunction

endpackage
`default_nettype wire

@@ rtl/slet_ram.sv @@
// Single-port-write, single-port-read memory with registered read data.
`default_nettype none
module slet_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ rtl/slet_out.sv @@
// Result holding stage and output register; marks the last word of each byte.
`default_nettype none
module slet_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slet_pkg::out_ctl_t ctl_i,
  output slet_pkg::out_sts_t     sts_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [7:0]             m_axis_tdata_o,
  output logic [2:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);
  import slet_pkg::*;

  res_t pend_q;
  logic pend_v_q;
  res_t out_q;
  logic out_last_q, out_v_q;
  logic push_ok, move;

  assign push_ok = !out_v_q || m_axis_tready_i;
  assign move    = pend_v_q && push_ok && (ctl_i.emit || ctl_i.fin);
  assign sts_o.can_emit = !pend_v_q || push_ok;
  assign sts_o.empty    = !pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ctl_i.emit) begin
        pend_v_q <= 1'b1;
      end else if (move) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      pend_q <= ctl_i.res;
    end
    if (move) begin
      out_q      <= pend_q;
      out_last_q <= ctl_i.fin;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tuser_o  = {out_q.too, out_q.kind};
  assign m_axis_tlast_o  = out_last_q;
endmodule
`default_nettype wire

@@ rtl/slet_seq.sv @@
// Command sequencer: edits the line and history memories and emits results.
`default_nettype none
module slet_seq #(
  parameter int unsigned LINE_LEN = 16,
  parameter int unsigned ARG_MAX  = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               echo_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  output logic                    in_ready_o,
  input  wire slet_pkg::out_sts_t sts_i,
  output slet_pkg::out_ctl_t      ctl_o
);
  import slet_pkg::*;

  localparam int unsigned LW = $clog2(LINE_LEN + 1);
  localparam int unsigned AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int unsigned CW = $clog2(ARG_MAX + 1);
  localparam logic [LW-1:0] LINE_FULL = LW'(LINE_LEN);
  localparam logic [CW-1:0] ARG_LIM   = CW'(ARG_MAX);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [LW-1:0] len_q, len_d, hlen_q, hlen_d, k_q, k_d, cnt_q, cnt_d;
  logic [2:0]    ph_q, ph_d;
  logic [CW-1:0] argc_q, argc_d;
  logic          inarg_q, inarg_d, too_q, too_d;

  logic          l_we, l_re, h_we, h_re;
  logic [AW-1:0] l_waddr;
  logic [7:0]    l_wdata, l_rdata, h_rdata;

  slet_ram #(.DEPTH(LINE_LEN), .AW(AW)) u_line (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(k_q[AW-1:0]), .rdata_o(l_rdata)
  );

  slet_ram #(.DEPTH(LINE_LEN), .AW(AW)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(k_q[AW-1:0]), .wdata_i(l_rdata),
    .re_i(h_re), .raddr_i(k_q[AW-1:0]), .rdata_o(h_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_OTHER;
      len_q   <= '0;
      hlen_q  <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      ph_q    <= '0;
      argc_q  <= '0;
      inarg_q <= 1'b0;
      too_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      hlen_q  <= hlen_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      argc_q  <= argc_d;
      inarg_q <= inarg_d;
      too_q   <= too_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    hlen_d  = hlen_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    ph_d    = ph_q;
    argc_d  = argc_q;
    inarg_d = inarg_q;
    too_d   = too_q;
    l_we    = 1'b0;
    l_re    = 1'b0;
    h_we    = 1'b0;
    h_re    = 1'b0;
    l_waddr = k_q[AW-1:0];
    l_wdata = h_rdata;
    ctl_o   = '0;
    ctl_o.res.kind = KIND_TERM;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FLUSH;
          k_d     = '0;
          ph_d    = '0;
          cmd_d   = CMD_OTHER;
          case (in_byte_i)
            C_CR, C_LF: begin
              cmd_d  = (in_byte_i == C_CR) ? CMD_CR : CMD_LF;
              argc_d = '0;
              inarg_d = 1'b0;
              too_d  = 1'b0;
              if (echo_i && in_byte_i == C_CR) begin
                state_d = S_NL;
              end else if (len_q != '0) begin
                state_d = S_CP_RD;
              end else begin
                state_d = S_TK_RD;
              end
            end
            C_ETX: begin
              cmd_d   = CMD_CC;
              len_d   = '0;
              state_d = S_NL;
            end
            C_NAK: begin
              len_d = '0;
              if (echo_i) begin
                cnt_d   = len_q;
                state_d = S_ERASE;
              end
            end
            C_BS, C_DEL: begin
              if (len_q != '0) begin
                len_d = len_q - 1'b1;
                if (echo_i) begin
                  cnt_d   = LW'(1);
                  state_d = S_ERASE;
                end
              end
            end
            C_TAB: begin
              if (hlen_q != '0) begin
                cmd_d   = CMD_TAB;
                cnt_d   = len_q;
                state_d = S_ERASE;
              end
            end
            default: begin
              // pending stage is empty here, so the word goes straight in
              if (len_q != LINE_FULL && in_byte_i >= C_SP && in_byte_i < C_DEL) begin
                l_we    = 1'b1;
                l_waddr = len_q[AW-1:0];
                l_wdata = in_byte_i;
                len_d   = len_q + 1'b1;
                if (echo_i) begin
                  ctl_o.emit     = 1'b1;
                  ctl_o.res.data = in_byte_i;
                end
              end else begin
                ctl_o.emit     = 1'b1;
                ctl_o.res.data = C_BELL;
              end
            end
          endcase
        end
      end

      S_NL: begin
        if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.data = C_LF;
          if (cmd_q == CMD_CC) begin
            state_d = S_PROMPT;
          end else if (len_q != '0) begin
            state_d = S_CP_RD;
          end else begin
            state_d = S_TK_RD;
          end
        end
      end

      S_ERASE: begin
        if (cnt_q == '0) begin
          state_d = (cmd_q == CMD_TAB) ? S_RC_RD : S_FLUSH;
          k_d     = '0;
        end else if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.data = (ph_q == 3'd1) ? C_SP : C_BS;
          if (ph_q == 3'd2) begin
            ph_d  = '0;
            cnt_d = cnt_q - 1'b1;
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end

      S_RC_RD: begin
        if (k_q == hlen_q) begin
          len_d   = hlen_q;
          state_d = S_FLUSH;
        end else begin
          h_re    = 1'b1;
          state_d = S_RC_EV;
        end
      end

      S_RC_EV: begin
        if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.data = h_rdata;
          l_we    = 1'b1;
          k_d     = k_q + 1'b1;
          state_d = S_RC_RD;
        end
      end

      S_CP_RD: begin
        if (k_q == len_q) begin
          hlen_d  = len_q;
          k_d     = '0;
          state_d = S_TK_RD;
        end else begin
          l_re    = 1'b1;
          state_d = S_CP_WR;
        end
      end

      S_CP_WR: begin
        h_we    = 1'b1;
        k_d     = k_q + 1'b1;
        state_d = S_CP_RD;
      end

      S_TK_RD: begin
        if (k_q == len_q) begin
          state_d = inarg_q ? S_TK_END : S_LEND;
        end else begin
          l_re    = 1'b1;
          state_d = S_TK_EV;
        end
      end

      S_TK_EV: begin
        if (!inarg_q && is_sep(l_rdata)) begin
          k_d     = k_q + 1'b1;
          state_d = S_TK_RD;
        end else if (sts_i.can_emit) begin
          ctl_o.emit = 1'b1;
          k_d        = k_q + 1'b1;
          state_d    = S_TK_RD;
          if (is_sep(l_rdata)) begin
            // argument closed by a separator; stop once the limit is reached
            ctl_o.res.kind = KIND_ARG_END;
            inarg_d = 1'b0;
            if (argc_q == ARG_LIM) begin
              too_d   = 1'b1;
              state_d = S_LEND;
            end
          end else begin
            ctl_o.res.kind = KIND_ARG;
            ctl_o.res.data = l_rdata;
            if (!inarg_q) begin
              inarg_d = 1'b1;
              argc_d  = argc_q + 1'b1;
            end
          end
        end
      end

      S_TK_END: begin
        if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.kind = KIND_ARG_END;
          state_d        = S_LEND;
        end
      end

      S_LEND: begin
        if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.kind = KIND_LINE;
          ctl_o.res.data = 8'(argc_q);
          ctl_o.res.too  = too_q;
          len_d          = '0;
          state_d        = (cmd_q == CMD_CR) ? S_PROMPT : S_FLUSH;
        end
      end

      S_PROMPT: begin
        if (sts_i.can_emit) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res.data = prompt_byte(ph_q);
          if (ph_q == 3'(PROMPT_LEN - 1)) begin
            state_d = S_FLUSH;
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        ctl_o.fin = 1'b1;
        if (sts_i.empty) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/serial_line_editor_tokenizer_core.sv @@
// Top level of the serial console line editor and tokenizer.
//
// Input stream: one received terminal byte per word on s_axis_tdata_i.
// Output stream: results in order; tdata carries the terminal or argument
// byte (argument count on a line end), tuser the kind and too-many flag,
// tlast marks the final word caused by one input byte.
// APB port: register 0 (byte address 0) is echo_enable, reset value 1.
//
// Timing: one byte is taken at a time. An echoed printable byte or a bell
// passes through the flush state before the next accept. Commands that walk
// the line or history memory read each character in a read state and then
// a use state (registered memory read, then use) and emit each erase,
// newline or prompt word in turn. The longest case is Tab on a full line
// with a full history. s_axis_tready_o is low from the accept until the
// cycle after the last result has entered the output register.
// Results pass through a holding stage and an output register, so the
// sequencer keeps working while the receiver stalls until both are full;
// it then waits without losing or repeating a word.
// Reset empties the line and the history and sets echo on. Memory
// contents are not cleared: the lengths bound every read.
`default_nettype none
module serial_line_editor_tokenizer_core #(
  parameter int unsigned LINE_LEN = 16,
  parameter int unsigned ARG_MAX  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic      [31:0] prdata_o,
  output logic             pready_o,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic      [2:0]  m_axis_tuser_o,   // [1:0] out_kind, [2] too_many_args
  output logic             m_axis_tlast_o    // out_last
);
  import slet_pkg::*;

  logic     echo_q;
  out_ctl_t ctl;
  out_sts_t sts;

  // Register write on the access phase; only register 0 exists.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b1;
    end else if (psel_i && penable_i && pwrite_i && pready_o && !paddr_i[2]) begin
      echo_q <= pwdata_i[0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? 32'd0 : {31'd0, echo_q};

  slet_seq #(.LINE_LEN(LINE_LEN), .ARG_MAX(ARG_MAX)) u_seq (
    .clk_i, .rst_ni,
    .echo_i     (echo_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  slet_out u_out (
    .clk_i, .rst_ni,
    .ctl_i (ctl),
    .sts_o (sts),
    .m_axis_tvalid_o, .m_axis_tready_i,
    .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
  );

  // Hold off the next byte right after one is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while previous byte still in work");

  // The too-many flag only rides on a line end.
  a_too_on_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tuser_o[1:0] == KIND_LINE)
    else $error("too_many_args set on a non line-end word");

  // The argument count never exceeds the limit.
  a_argc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == KIND_LINE |-> m_axis_tdata_o <= 8'(ARG_MAX))
    else $error("argument count above limit");
endmodule
`default_nettype wire
